### rtl/core/cbb_pkg.sv
package cbb_pkg;

    // widths fixed by the item and register formats
    localparam int unsigned PIX_W      = 16;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned CH5_W      = 5;
    localparam int unsigned ALPHA_W    = 8;
    localparam int unsigned COORD_W    = 8;
    localparam int unsigned DEST_W     = 12;
    localparam int unsigned DIM_REG_W  = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // packed colour layout: red 15..11, green 10..6, bit 5 zero, blue 4..0
    localparam int unsigned RED_LSB    = 11;
    localparam int unsigned GREEN_LSB  = 6;
    localparam int unsigned BLUE_LSB   = 0;
    localparam int unsigned CH_DROP    = 3;

    localparam logic [PIX_W-1:0] STORE_INIT = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLIT_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOUR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ALPHA   = 3'd6;

    // item opcodes
    localparam logic OP_PIXEL    = 1'b0;
    localparam logic OP_READBACK = 1'b1;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_ALPHA = 2'd1,
        MODE_KEY   = 2'd2,
        MODE_CONST = 2'd3
    } blit_mode_t;

    typedef enum logic [1:0] {
        ST_WRITTEN  = 2'd0,
        ST_CLIPPED  = 2'd1,
        ST_SKIPPED  = 2'd2,
        ST_READBACK = 2'd3
    } status_t;

endpackage

### rtl/core/cbb_if.sv
// command channel: source pixels and readback requests
interface cbb_cmd_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [cbb_pkg::CHAN_W-1:0]       blue;
    logic [cbb_pkg::CHAN_W-1:0]       green;
    logic [cbb_pkg::CHAN_W-1:0]       red;
    logic [cbb_pkg::ALPHA_W-1:0]      pixel_alpha;
    logic [cbb_pkg::COORD_W-1:0]      read_col;
    logic [cbb_pkg::COORD_W-1:0]      read_row;

    modport source (
        output valid, opcode, blue, green, red, pixel_alpha, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, opcode, blue, green, red, pixel_alpha, read_col, read_row,
        output ready
    );
endinterface

// response channel: one item per command
interface cbb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [cbb_pkg::PIX_W-1:0]    pixel_value;
    logic                         last_pixel;

    modport source (
        output valid, status, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, status, pixel_value, last_pixel,
        output ready
    );
endinterface

// register write channel
interface cbb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cbb_pkg::CFG_IDX_W-1:0]      index;
    logic [cbb_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/cbb_blend.sv
// per-channel blend of two packed colours: dst + (src - dst) * alpha / 255
module cbb_blend (
    input  logic [cbb_pkg::PIX_W-1:0]   src,
    input  logic [cbb_pkg::PIX_W-1:0]   dst,
    input  logic [cbb_pkg::ALPHA_W-1:0] alpha,
    output logic [cbb_pkg::PIX_W-1:0]   blended
);

    localparam int unsigned C = cbb_pkg::CH5_W;

    // divide by 255 on a magnitude below 2^13: (n + (n >> 8) + 1) >> 8
    function automatic logic [C-1:0] blend5(
        input logic [C-1:0]                s,
        input logic [C-1:0]                d,
        input logic [cbb_pkg::ALPHA_W-1:0] a
    );
        logic signed [C:0]  diff;
        logic               neg;
        logic [C-1:0]       mag;
        logic [12:0]        prod;
        logic [13:0]        acc;
        logic [C-1:0]       q;
        diff = $signed({1'b0, s}) - $signed({1'b0, d});
        neg  = diff[C];
        mag  = neg ? C'(-diff) : C'(diff);
        prod = 13'(mag) * 13'(a);
        acc  = 14'(prod) + 14'(prod[12:8]) + 14'd1;
        q    = acc[8 +: C];
        return neg ? (d - q) : (d + q);
    endfunction

    always_comb
    begin
        blended = '0;
        blended[cbb_pkg::RED_LSB +: C] =
            blend5(src[cbb_pkg::RED_LSB +: C], dst[cbb_pkg::RED_LSB +: C], alpha);
        blended[cbb_pkg::GREEN_LSB +: C] =
            blend5(src[cbb_pkg::GREEN_LSB +: C], dst[cbb_pkg::GREEN_LSB +: C], alpha);
        blended[cbb_pkg::BLUE_LSB +: C] =
            blend5(src[cbb_pkg::BLUE_LSB +: C], dst[cbb_pkg::BLUE_LSB +: C], alpha);
    end

endmodule

### rtl/core/clipped_blit_blend_engine.sv
// Clipped blit and blend engine. Source pixels arrive on cmd in raster order and are
// placed at (dest_x + column, dest_y + row) in a FRAME_WIDTH x FRAME_HEIGHT store of
// packed 5:5:5 colours (red 15..11, green 10..6, bit 5 zero, blue 4..0); pixels that
// land outside the frame are reported as clipped. blit_mode picks copy, per-pixel
// alpha blend (alpha zero skips), colour-key skip, or constant-alpha blend. A readback
// command returns one stored entry. Every command gives exactly one rsp item, in order.
// Throughput is one item per clock unless rsp back-pressure stalls it: the frame memory has
// one read and one write port, the read is issued as the item is accepted and the blended
// value is written back from stage 1, with a bypass for an item that reads the entry just
// being written. The result passes through the stage 1 registers and the output register
// to rsp. After reset the store is swept to 0xFFFF one entry per cycle, FRAME_WIDTH *
// FRAME_HEIGHT entries (65536 with the defaults); cmd.ready stays low during the sweep,
// register writes are taken. Registers must only be written while no command is in flight.
module clipped_blit_blend_engine #(
    parameter int unsigned FRAME_WIDTH    = 256,
    parameter int unsigned FRAME_HEIGHT   = 256,
    parameter int unsigned MAX_SOURCE_DIM = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    cbb_cmd_if.sink    cmd,
    cbb_rsp_if.source  rsp,
    cbb_cfg_if.sink    cfg
);

    localparam int unsigned DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(MAX_SOURCE_DIM);
    localparam int unsigned POS_W  = 14;
    localparam int unsigned PW     = cbb_pkg::PIX_W;

    // ---------------------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------------------
    cbb_pkg::blit_mode_t                     blit_mode_reg;
    logic signed [cbb_pkg::DEST_W-1:0]       dest_x_reg;
    logic signed [cbb_pkg::DEST_W-1:0]       dest_y_reg;
    logic [cbb_pkg::DIM_REG_W-1:0]           source_width_reg;
    logic [cbb_pkg::DIM_REG_W-1:0]           source_height_reg;
    logic [PW-1:0]                           key_colour_reg;
    logic [cbb_pkg::ALPHA_W-1:0]             fixed_alpha_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blit_mode_reg     <= cbb_pkg::MODE_COPY;
            dest_x_reg        <= '0;
            dest_y_reg        <= '0;
            source_width_reg  <= cbb_pkg::DIM_REG_W'(1);
            source_height_reg <= cbb_pkg::DIM_REG_W'(1);
            key_colour_reg    <= '0;
            fixed_alpha_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cbb_pkg::CFG_BLIT_MODE:
                    blit_mode_reg <= cbb_pkg::blit_mode_t'(cfg.data[1:0]);
                cbb_pkg::CFG_DEST_X:
                    dest_x_reg <= $signed(cfg.data[cbb_pkg::DEST_W-1:0]);
                cbb_pkg::CFG_DEST_Y:
                    dest_y_reg <= $signed(cfg.data[cbb_pkg::DEST_W-1:0]);
                cbb_pkg::CFG_SOURCE_WIDTH:
                    source_width_reg <= cfg.data[cbb_pkg::DIM_REG_W-1:0];
                cbb_pkg::CFG_SOURCE_HEIGHT:
                    source_height_reg <= cfg.data[cbb_pkg::DIM_REG_W-1:0];
                cbb_pkg::CFG_KEY_COLOUR:
                    key_colour_reg <= cfg.data;
                cbb_pkg::CFG_FIXED_ALPHA:
                    fixed_alpha_reg <= cfg.data[cbb_pkg::ALPHA_W-1:0];
                default:
                    ; // indexes past the register list are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // post-reset sweep of the frame store
    // ---------------------------------------------------------------------------------
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------------------
    // pipeline handshake
    // ---------------------------------------------------------------------------------
    logic p1_valid_reg;
    logic rsp_valid_reg;
    logic out_adv;      // output register can take the stage 1 item
    logic cmd_ready;
    logic cmd_accept;

    assign out_adv    = !rsp_valid_reg || rsp.ready;
    assign cmd_ready  = !clearing_reg && (!p1_valid_reg || out_adv);
    assign cmd_accept = cmd.valid && cmd_ready;
    assign cmd.ready  = cmd_ready;

    // ---------------------------------------------------------------------------------
    // stage 0: position, clip, address, raster counters
    // ---------------------------------------------------------------------------------
    logic [CNT_W-1:0] source_col_reg, source_col_next;
    logic [CNT_W-1:0] source_row_reg, source_row_next;
    logic [CNT_W-1:0] col_limit;    // clamped width minus one
    logic [CNT_W-1:0] row_limit;    // clamped height minus one
    logic             a_last;

    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    a_clip;
    logic                    a_rb_ok;
    logic [ADDR_W-1:0]       a_addr;
    logic [PW-1:0]           a_src;
    logic                    a_skip;
    logic                    a_blend;
    logic [cbb_pkg::ALPHA_W-1:0] a_alpha;

    always_comb
    begin
        // width and height saturate to 1..MAX_SOURCE_DIM
        if (source_width_reg == '0)
            col_limit = '0;
        else if (32'(source_width_reg) > MAX_SOURCE_DIM)
            col_limit = CNT_W'(MAX_SOURCE_DIM - 1);
        else
            col_limit = CNT_W'(source_width_reg - 1'b1);

        if (source_height_reg == '0)
            row_limit = '0;
        else if (32'(source_height_reg) > MAX_SOURCE_DIM)
            row_limit = CNT_W'(MAX_SOURCE_DIM - 1);
        else
            row_limit = CNT_W'(source_height_reg - 1'b1);
    end

    always_comb
    begin
        source_col_next = source_col_reg;
        source_row_next = source_row_reg;
        a_last          = 1'b0;
        if (source_col_reg >= col_limit)
        begin
            source_col_next = '0;
            if (source_row_reg >= row_limit)
            begin
                source_row_next = '0;
                a_last          = 1'b1;
            end
            else
            begin
                source_row_next = source_row_reg + 1'b1;
            end
        end
        else
        begin
            source_col_next = source_col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_col_reg <= '0;
            source_row_reg <= '0;
        end
        else if (cmd_accept && cmd.opcode == cbb_pkg::OP_PIXEL)
        begin
            source_col_reg <= source_col_next;
            source_row_reg <= source_row_next;
        end
    end

    always_comb
    begin
        px = POS_W'(dest_x_reg) + POS_W'($signed({1'b0, source_col_reg}));
        py = POS_W'(dest_y_reg) + POS_W'($signed({1'b0, source_row_reg}));

        a_clip  = (px < 0) || (py < 0) || (px >= FRAME_WIDTH) || (py >= FRAME_HEIGHT);
        a_rb_ok = (32'(cmd.read_col) < FRAME_WIDTH) && (32'(cmd.read_row) < FRAME_HEIGHT);

        // address is only meaningful when in range; truncation elsewhere is harmless
        if (cmd.opcode == cbb_pkg::OP_READBACK)
            a_addr = ADDR_W'(cmd.read_row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(cmd.read_col);
        else
            a_addr = ADDR_W'($unsigned(py)) * ADDR_W'(FRAME_WIDTH)
                   + ADDR_W'($unsigned(px));

        // 8-bit channels down to 5:5:5
        a_src = {cmd.red[cbb_pkg::CHAN_W-1:cbb_pkg::CH_DROP],
                 cmd.green[cbb_pkg::CHAN_W-1:cbb_pkg::CH_DROP],
                 1'b0,
                 cmd.blue[cbb_pkg::CHAN_W-1:cbb_pkg::CH_DROP]};

        a_skip  = 1'b0;
        a_blend = 1'b0;
        a_alpha = cmd.pixel_alpha;
        case (blit_mode_reg)
            cbb_pkg::MODE_COPY:
                ;
            cbb_pkg::MODE_ALPHA:
            begin
                a_skip  = (cmd.pixel_alpha == '0);
                a_blend = 1'b1;
            end
            cbb_pkg::MODE_KEY:
                a_skip = (a_src == key_colour_reg);
            cbb_pkg::MODE_CONST:
            begin
                a_blend = 1'b1;
                a_alpha = fixed_alpha_reg;
            end
            default:
                ;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // frame memory: one read port (stage 0), one write port (stage 1 or sweep)
    // ---------------------------------------------------------------------------------
    logic [PW-1:0]     frame_mem [DEPTH];
    logic [PW-1:0]     mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PW-1:0]     mem_wdata;
    logic              wb_en;     // stage 1 write-back
    logic [PW-1:0]     wb_data;
    logic [ADDR_W-1:0] p1_addr_reg;

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = cbb_pkg::STORE_INIT;
        end
        else
        begin
            mem_we    = wb_en;
            mem_waddr = p1_addr_reg;
            mem_wdata = wb_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        if (cmd_accept)
            mem_rdata_reg <= frame_mem[a_addr];
    end

    // ---------------------------------------------------------------------------------
    // stage 1 registers
    // ---------------------------------------------------------------------------------
    logic                        p1_read_reg;
    logic                        p1_rb_ok_reg;
    logic                        p1_clip_reg;
    logic                        p1_skip_reg;
    logic                        p1_blend_reg;
    logic                        p1_last_reg;
    logic [PW-1:0]               p1_src_reg;
    logic [cbb_pkg::ALPHA_W-1:0] p1_alpha_reg;
    logic                        p1_fwd_reg;       // entry written as this item was read
    logic [PW-1:0]               p1_fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (cmd_ready)
            p1_valid_reg <= cmd_accept;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            p1_read_reg     <= (cmd.opcode == cbb_pkg::OP_READBACK);
            p1_rb_ok_reg    <= a_rb_ok;
            p1_clip_reg     <= a_clip;
            p1_skip_reg     <= a_skip;
            p1_blend_reg    <= a_blend;
            p1_last_reg     <= (cmd.opcode == cbb_pkg::OP_PIXEL) && a_last;
            p1_addr_reg     <= a_addr;
            p1_src_reg      <= a_src;
            p1_alpha_reg    <= a_alpha;
            p1_fwd_reg      <= wb_en && (p1_addr_reg == a_addr);
            p1_fwd_data_reg <= wb_data;
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 1: blend and write back
    // ---------------------------------------------------------------------------------
    logic [PW-1:0]    p1_dst;
    logic [PW-1:0]    p1_blended;
    cbb_pkg::status_t p1_status;
    logic [PW-1:0]    p1_value;

    assign p1_dst = p1_fwd_reg ? p1_fwd_data_reg : mem_rdata_reg;

    cbb_blend u_blend (
        .src     (p1_src_reg),
        .dst     (p1_dst),
        .alpha   (p1_alpha_reg),
        .blended (p1_blended)
    );

    assign wb_data = p1_blend_reg ? p1_blended : p1_src_reg;
    assign wb_en   = p1_valid_reg && out_adv && !p1_read_reg && !p1_clip_reg && !p1_skip_reg;

    always_comb
    begin
        if (p1_read_reg)
        begin
            p1_status = cbb_pkg::ST_READBACK;
            p1_value  = p1_rb_ok_reg ? p1_dst : '0;
        end
        else if (p1_clip_reg)
        begin
            p1_status = cbb_pkg::ST_CLIPPED;
            p1_value  = '0;
        end
        else if (p1_skip_reg)
        begin
            p1_status = cbb_pkg::ST_SKIPPED;
            p1_value  = '0;
        end
        else
        begin
            p1_status = cbb_pkg::ST_WRITTEN;
            p1_value  = wb_data;
        end
    end

    // ---------------------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------------------
    cbb_pkg::status_t rsp_status_reg;
    logic [PW-1:0]    rsp_value_reg;
    logic             rsp_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_adv)
            rsp_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && p1_valid_reg)
        begin
            rsp_status_reg <= p1_status;
            rsp_value_reg  <= p1_value;
            rsp_last_reg   <= p1_last_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.pixel_value = rsp_value_reg;
    assign rsp.last_pixel  = rsp_last_reg;

endmodule

### dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbb_pkg::*;

    // frame geometry handed to the block, the mirror uses the same numbers
    localparam int unsigned FRAME_W      = 256;
    localparam int unsigned FRAME_H      = 256;
    localparam int unsigned MAX_DIM      = 1024;
    // no register lives at this index, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int unsigned RANDOM_ITEMS = 1000;
    // bound covers the post-reset store sweep and all the test items
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    typedef struct packed {
        logic                opcode;
        logic [CHAN_W-1:0]   blue;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   red;
        logic [ALPHA_W-1:0]  pixel_alpha;
        logic [COORD_W-1:0]  read_col;
        logic [COORD_W-1:0]  read_row;
    } blit_cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [PIX_W-1:0]    pixel_value;
        logic                last_pixel;
    } blit_rsp_t;

    // mirror of the frame store, the raster counters and the registers;
    // keeps the queue of responses the block still owes
    class frame_mirror;
        bit [PIX_W-1:0]   store [FRAME_W*FRAME_H];
        blit_mode_t       mode;
        int               org_x;
        int               org_y;
        int unsigned      width_reg;
        int unsigned      height_reg;
        bit [PIX_W-1:0]   key;
        bit [ALPHA_W-1:0] const_alpha;
        int unsigned      col;
        int unsigned      row;
        blit_rsp_t        pending [$];
        int unsigned      errors;
        int unsigned      n_written;
        int unsigned      n_clipped;
        int unsigned      n_skipped;
        int unsigned      n_readback;
        int unsigned      n_bitmaps;

        function new();
            foreach (store[i]) store[i] = STORE_INIT;
            mode        = MODE_COPY;
            org_x       = 0;
            org_y       = 0;
            width_reg   = 1;
            height_reg  = 1;
            key         = '0;
            const_alpha = '0;
            col         = 0;
            row         = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BLIT_MODE:     mode = blit_mode_t'(val[1:0]);
                CFG_DEST_X:        org_x = int'($signed(val[DEST_W-1:0]));
                CFG_DEST_Y:        org_y = int'($signed(val[DEST_W-1:0]));
                CFG_SOURCE_WIDTH:  width_reg = val[DIM_REG_W-1:0];
                CFG_SOURCE_HEIGHT: height_reg = val[DIM_REG_W-1:0];
                CFG_KEY_COLOUR:    key = val[PIX_W-1:0];
                CFG_FIXED_ALPHA:   const_alpha = val[ALPHA_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned d);
            if (d < 1) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        // dst + (src - dst) * a / 255, division truncating toward zero
        function bit [CH5_W-1:0] mix5(bit [CH5_W-1:0] s, bit [CH5_W-1:0] d, bit [7:0] a);
            int diff;
            diff = int'(s) - int'(d);
            return CH5_W'((diff * int'(a)) / 255 + int'(d));
        endfunction

        function bit [PIX_W-1:0] mix_pixel(bit [PIX_W-1:0] s, bit [PIX_W-1:0] d, bit [7:0] a);
            return {mix5(s[15:11], d[15:11], a), mix5(s[10:6], d[10:6], a), 1'b0,
                    mix5(s[4:0], d[4:0], a)};
        endfunction

        function void take_command(blit_cmd_t c);
            blit_rsp_t      exp_r;
            int unsigned    w;
            int unsigned    h;
            int             px;
            int             py;
            int unsigned    slot;
            bit [PIX_W-1:0] src;
            bit [PIX_W-1:0] res;
            bit             skip;
            exp_r = '0;
            if (c.opcode == OP_READBACK) begin
                exp_r.status = ST_READBACK;
                if (c.read_col < FRAME_W && c.read_row < FRAME_H)
                    exp_r.pixel_value = store[int'(c.read_row) * FRAME_W + int'(c.read_col)];
            end else begin
                w   = clamp_dim(width_reg);
                h   = clamp_dim(height_reg);
                px  = org_x + int'(col);
                py  = org_y + int'(row);
                src = {c.red[7:3], c.green[7:3], 1'b0, c.blue[7:3]};
                if (px < 0 || py < 0 || px >= int'(FRAME_W) || py >= int'(FRAME_H)) begin
                    exp_r.status = ST_CLIPPED;
                end else begin
                    slot = py * FRAME_W + px;
                    skip = 1'b0;
                    res  = src;
                    case (mode)
                        MODE_ALPHA: begin
                            if (c.pixel_alpha == 0) skip = 1'b1;
                            else res = mix_pixel(src, store[slot], c.pixel_alpha);
                        end
                        MODE_KEY:   skip = (src == key);
                        MODE_CONST: res = mix_pixel(src, store[slot], const_alpha);
                        default: ;
                    endcase
                    if (skip) begin
                        exp_r.status = ST_SKIPPED;
                    end else begin
                        exp_r.status      = ST_WRITTEN;
                        exp_r.pixel_value = res;
                        store[slot]       = res;
                    end
                end
                if (col >= w - 1) begin
                    col = 0;
                    if (row >= h - 1) begin
                        row = 0;
                        exp_r.last_pixel = 1'b1;
                    end else begin
                        row++;
                    end
                end else begin
                    col++;
                end
            end
            pending.push_back(exp_r);
        endfunction

        function void check_response(blit_rsp_t got);
            blit_rsp_t want;
            if (pending.size() == 0) begin
                $error("response with nothing outstanding: status %0d value %h last %0d",
                       got.status, got.pixel_value, got.last_pixel);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.pixel_value !== want.pixel_value) begin
                $error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.last_pixel !== want.last_pixel) begin
                $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
                errors++;
            end
            case (want.status)
                ST_WRITTEN: n_written++;
                ST_CLIPPED: n_clipped++;
                ST_SKIPPED: n_skipped++;
                default:    n_readback++;
            endcase
            if (want.last_pixel) n_bitmaps++;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    bit          steady = 1'b0;   // no idling on either side while set
    int unsigned cycles = 0;
    frame_mirror sb;

    cbb_cmd_if cmd ();
    cbb_rsp_if rsp ();
    cbb_cfg_if cfg ();

    clipped_blit_blend_engine #(
        .FRAME_WIDTH    (FRAME_W),
        .FRAME_HEIGHT   (FRAME_H),
        .MAX_SOURCE_DIM (MAX_DIM)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run-away guard, allowing for the store sweep after reset
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // response side: random back-pressure, check every accepted item
    always @(posedge clk)
    begin : rsp_monitor
        blit_rsp_t seen;
        if (rst_n && rsp.valid && rsp.ready) begin
            seen.status      = rsp.status;
            seen.pixel_value = rsp.pixel_value;
            seen.last_pixel  = rsp.last_pixel;
            sb.check_response(seen);
        end
        rsp.ready <= steady || ($urandom_range(99) >= 35);
    end

    // register write, valid is left high so back-to-back writes stay dense
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        sb.write_register(idx, val);
    endtask

    // full register set, unused upper data bits get random junk
    task automatic configure_blit(input blit_mode_t m, input int dx, input int dy,
                                  input int unsigned w, input int unsigned h,
                                  input logic [PIX_W-1:0] key, input logic [ALPHA_W-1:0] fa);
        set_reg(CFG_BLIT_MODE, {14'($urandom), 2'(m)});
        set_reg(CFG_DEST_X, {4'($urandom), 12'(dx)});
        set_reg(CFG_DEST_Y, {4'($urandom), 12'(dy)});
        set_reg(CFG_SOURCE_WIDTH, {5'($urandom), 11'(w)});
        set_reg(CFG_SOURCE_HEIGHT, {5'($urandom), 11'(h)});
        set_reg(CFG_KEY_COLOUR, key);
        set_reg(CFG_FIXED_ALPHA, {8'($urandom), fa});
        cfg.valid <= 1'b0;
    endtask

    // sender inserts idle gaps with odds of 35 in a hundred unless in the steady stretch
    task automatic sender_gap();
        while (!steady && $urandom_range(99) < 35) begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic issue(input blit_cmd_t c);
        sender_gap();
        cmd.valid       <= 1'b1;
        cmd.opcode      <= c.opcode;
        cmd.blue        <= c.blue;
        cmd.green       <= c.green;
        cmd.red         <= c.red;
        cmd.pixel_alpha <= c.pixel_alpha;
        cmd.read_col    <= c.read_col;
        cmd.read_row    <= c.read_row;
        do @(posedge clk); while (!cmd.ready);
        sb.take_command(c);
    endtask

    // hold off until every owed response is back, block is then idle
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // source pixel, readback coordinates are don't-care and randomized
    function automatic blit_cmd_t pix(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic [7:0] a);
        blit_cmd_t c;
        c = {OP_PIXEL, b, g, r, a, 8'($urandom), 8'($urandom)};
        return c;
    endfunction

    // readback, colour fields are don't-care and randomized
    function automatic blit_cmd_t peek(input logic [7:0] x, input logic [7:0] y);
        blit_cmd_t c;
        c = {OP_READBACK, 32'($urandom), x, y};
        return c;
    endfunction

    function automatic int pick_origin();
        case ($urandom_range(9))
            0:       return -2048;
            1:       return 2047;
            2:       return 240 + int'($urandom_range(20));
            default: return int'($urandom_range(270)) - 10;
        endcase
    endfunction

    // mostly tiny bitmaps so last_pixel comes often, a few huge or out of range
    function automatic int unsigned pick_dim();
        case ($urandom_range(11))
            0:       return 0;
            1:       return 2047;
            2:       return MAX_DIM;
            3:       return $urandom_range(MAX_DIM + 1, 2046);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial
    begin : stimulus
        blit_cmd_t    c;
        blit_mode_t   m;
        int           dx;
        int           dy;
        logic [7:0]   kr;
        logic [7:0]   kg;
        logic [7:0]   kb;
        logic [15:0]  key;
        logic [7:0]   fa;
        int unsigned  n;
        int unsigned  random_sent;
        int unsigned  phases;

        sb = new();
        random_sent = 0;
        phases      = 0;
        cmd.valid = 1'b0;
        cmd.opcode = OP_PIXEL;
        cmd.blue = '0;
        cmd.green = '0;
        cmd.red = '0;
        cmd.pixel_alpha = '0;
        cmd.read_col = '0;
        cmd.read_row = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_BLIT_MODE;
        cfg.data = '0;
        rsp.ready = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // plain copy into a 2x2 corner: full-scale, zero and single channels,
        // then readback of written and untouched entries; bitmap ends on item 4
        set_reg(CFG_UNUSED, 16'hFFFF);
        configure_blit(MODE_COPY, 0, 0, 2, 2, 16'h0000, 8'd0);
        issue(pix(8'd255, 8'd255, 8'd255, 8'd255));
        issue(pix(8'd0, 8'd0, 8'd0, 8'd0));
        issue(pix(8'd255, 8'd0, 8'd0, 8'd128));
        issue(pix(8'd7, 8'd255, 8'd248, 8'd1));
        issue(peek(8'd0, 8'd0));
        issue(peek(8'd1, 8'd0));
        issue(peek(8'd255, 8'd255));
        drain();
        phases++;

        // per-pixel alpha: zero alpha skips, full, half and minimum weight
        configure_blit(MODE_ALPHA, 0, 0, 2, 2, 16'h0000, 8'd0);
        issue(pix(8'd0, 8'd0, 8'd0, 8'd0));
        issue(pix(8'd0, 8'd0, 8'd0, 8'd255));
        issue(pix(8'd255, 8'd255, 8'd255, 8'd128));
        issue(pix(8'd128, 8'd64, 8'd32, 8'd1));
        issue(peek(8'd0, 8'd0));
        drain();
        phases++;

        // colour key magenta: exact match and match through dropped low bits skip
        configure_blit(MODE_KEY, 0, 0, 2, 2, 16'hF81F, 8'd0);
        issue(pix(8'd255, 8'd0, 8'd255, 8'd0));
        issue(pix(8'd248, 8'd7, 8'd252, 8'd77));
        issue(pix(8'd0, 8'd255, 8'd0, 8'd0));
        issue(pix(8'd255, 8'd8, 8'd255, 8'd0));
        drain();
        phases++;

        // constant alpha zero keeps the old colour minus bit 5; placed so that
        // three of the four pixels clip off the left and bottom edges
        configure_blit(MODE_CONST, -1, 255, 2, 2, 16'h0000, 8'd0);
        issue(pix(8'd10, 8'd20, 8'd30, 8'd0));
        issue(pix(8'd10, 8'd20, 8'd30, 8'd0));
        issue(pix(8'd10, 8'd20, 8'd30, 8'd0));
        issue(pix(8'd10, 8'd20, 8'd30, 8'd0));
        issue(peek(8'd0, 8'd255));
        drain();
        phases++;

        // constant alpha full weight on a one-pixel bitmap
        configure_blit(MODE_CONST, 0, 0, 1, 1, 16'hFFFF, 8'd255);
        issue(pix(8'd99, 8'd150, 8'd201, 8'd0));
        drain();
        phases++;

        // origin extremes with oversize width and zero height: everything clips
        configure_blit(MODE_COPY, 2047, -2048, 2047, 0, 16'hFFFF, 8'd255);
        issue(pix(8'd1, 8'd2, 8'd3, 8'd4));
        issue(pix(8'd255, 8'd255, 8'd255, 8'd255));

        // random register settings, each followed by a burst of items
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            steady = (random_sent >= 300 && random_sent < 550);
            m  = blit_mode_t'($urandom_range(3));
            dx = pick_origin();
            dy = pick_origin();
            kr = 8'($urandom);
            kg = 8'($urandom);
            kb = 8'($urandom);
            key = {kr[7:3], kg[7:3], 1'b0, kb[7:3]};
            // now and then a fully random key; one with bit 5 set never matches
            if ($urandom_range(7) == 0) key = 16'($urandom);
            case ($urandom_range(5))
                0:       fa = 8'd0;
                1:       fa = 8'd255;
                default: fa = 8'($urandom);
            endcase
            configure_blit(m, dx, dy, pick_dim(), pick_dim(), key, fa);
            phases++;
            n = $urandom_range(8, 60);
            repeat (n) begin
                if ($urandom_range(99) < 20) begin
                    // readbacks mostly land on the area just drawn
                    if ($urandom_range(9) < 7)
                        c = peek(8'(dx + int'($urandom_range(15))),
                                 8'(dy + int'($urandom_range(15))));
                    else
                        c = peek(8'($urandom), 8'($urandom));
                end else begin
                    c = pix(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                    case ($urandom_range(7))
                        0: c.pixel_alpha = 8'd0;
                        1: c.pixel_alpha = 8'd255;
                        default: ;
                    endcase
                    // key mode: a good share of pixels hit the key colour
                    if (m == MODE_KEY && $urandom_range(9) < 4) begin
                        c.red   = {kr[7:3], 3'($urandom)};
                        c.green = {kg[7:3], 3'($urandom)};
                        c.blue  = {kb[7:3], 3'($urandom)};
                    end
                end
                issue(c);
                random_sent++;
            end
        end
        drain();
        steady = 1'b0;
        // leave room for any stray response
        repeat (8) @(posedge clk);

        $display("checked %0d responses: %0d written, %0d clipped, %0d skipped, %0d readbacks",
                 sb.n_written + sb.n_clipped + sb.n_skipped + sb.n_readback,
                 sb.n_written, sb.n_clipped, sb.n_skipped, sb.n_readback);
        $display("%0d source bitmaps completed over %0d register settings",
                 sb.n_bitmaps, phases);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
